[hw/rtl/izh_pkg.sv]
package izh_pkg;

	// Fixed-point format: signed 32-bit words with FRAC_BITS fraction bits
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int PROD_W    = 2 * WORD_W;
	// Wide enough for the largest exact sum before saturation
	localparam int SUM_W     = 40;

	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(WORD_MAX);
	localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(WORD_MIN);
	localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(WORD_MAX);
	localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(WORD_MIN);

	// Equation constants
	localparam longint K004_L = ((longint'(4) <<< FRAC_BITS) + 50) / 100;
	localparam logic signed [WORD_W-1:0] K004 = WORD_W'(K004_L);
	localparam logic signed [WORD_W-1:0] K140 = WORD_W'(longint'(140) <<< FRAC_BITS);
	localparam logic signed [WORD_W-1:0] K30  = WORD_W'(longint'(30) <<< FRAC_BITS);

	// Register reset values
	localparam logic signed [WORD_W-1:0] RST_A      = 32'sd1311;
	localparam logic signed [WORD_W-1:0] RST_B      = 32'sd13107;
	localparam logic signed [WORD_W-1:0] RST_C      = -32'sd4259840;
	localparam logic signed [WORD_W-1:0] RST_D      = 32'sd524288;
	localparam logic [WORD_W-2:0]        RST_ALPHA  = 31'd65536;
	localparam logic signed [WORD_W-1:0] RST_INIT_V = -32'sd4259840;
	localparam logic signed [WORD_W-1:0] RST_INIT_U = -32'sd851968;

	typedef enum logic [2:0] {
		REG_A,
		REG_B,
		REG_C,
		REG_D,
		REG_ALPHA,
		REG_INIT_V,
		REG_INIT_U
	} izh_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VV,
		ST_Q1,
		ST_K,
		ST_DV,
		ST_BV,
		ST_Q2,
		ST_A,
		ST_Q3,
		ST_AD,
		ST_NU,
		ST_AV,
		ST_NV
	} izh_state_t;

	typedef struct packed {
		logic                     neighbor_spiked;
		logic signed [WORD_W-1:0] synapse_weight;
		logic                     last_of_tick;
	} izh_in_t;

	typedef struct packed {
		logic                     fired;
		logic signed [WORD_W-1:0] voltage;
		logic signed [WORD_W-1:0] recovery;
	} izh_out_t;

	// Clamp an exact sum to the word range
	function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
		logic signed [WORD_W-1:0] r;
		if (x > SUM_MAX) begin
			r = WORD_MAX;
		end else if (x < SUM_MIN) begin
			r = WORD_MIN;
		end else begin
			r = x[WORD_W-1:0];
		end
		return r;
	endfunction

	// Scale a full product back to the word format, flooring, then clamp
	function automatic logic signed [WORD_W-1:0] qscale(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		logic signed [WORD_W-1:0] r;
		s = p >>> FRAC_BITS;
		if (s > PROD_MAX) begin
			r = WORD_MAX;
		end else if (s < PROD_MIN) begin
			r = WORD_MIN;
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/izhikevich_neuron_step.sv]
// Non-closing item: accumulated, and a new item is taken on the next cycle.
// Closing item: runs ST_VV to ST_NV, commits once the output register is free, then
// returns to ST_IDLE; one shared 32x32 multiplier is used six times, products registered.
// A finished result waits in an output register while new items are taken.
// Reset: registers take their default values, voltage and recovery load the
// default initial values, the current accumulator clears, no result pending.
module izhikevich_neuron_step
	import izh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  izh_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output izh_out_t              out_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [WORD_W-1:0]     cfg_data
);

	izh_state_t state_q, state_d;

	logic signed [WORD_W-1:0] a_q, b_q, c_q, d_q;
	logic [WORD_W-2:0]        alpha_q;
	logic signed [WORD_W-1:0] v_q, u_q, cur_q;

	logic signed [PROD_W-1:0] p_q;
	logic signed [WORD_W-1:0] t_q, dv_q, nu_q;
	logic signed [SUM_W-1:0]  base_q;

	logic                     out_valid_q;
	izh_out_t                 out_q;

	logic                     in_xfer;
	logic                     mul_en;
	logic signed [WORD_W-1:0] mul_a, mul_b;
	logic                     commit;
	logic signed [WORD_W-1:0] pq;
	logic signed [WORD_W-1:0] nv;
	logic                     fire;

	assign in_xfer = in_valid && !in_stall;
	assign pq      = qscale(p_q);
	assign nv      = sat_sum(SUM_W'(v_q) + SUM_W'(pq));
	assign fire    = (nv >= K30);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and multiplier operand select
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mul_en   = 1'b0;
		mul_a    = v_q;
		mul_b    = v_q;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && in_item.last_of_tick) begin
					state_d = ST_VV;
				end
			end
			ST_VV: begin
				mul_en  = 1'b1;
				state_d = ST_Q1;
			end
			ST_Q1: state_d = ST_K;
			ST_K: begin
				mul_en  = 1'b1;
				mul_a   = K004;
				mul_b   = t_q;
				state_d = ST_DV;
			end
			ST_DV: state_d = ST_BV;
			ST_BV: begin
				mul_en  = 1'b1;
				mul_a   = b_q;
				state_d = ST_Q2;
			end
			ST_Q2: state_d = ST_A;
			ST_A: begin
				mul_en  = 1'b1;
				mul_a   = a_q;
				mul_b   = t_q;
				state_d = ST_Q3;
			end
			ST_Q3: state_d = ST_AD;
			ST_AD: begin
				mul_en  = 1'b1;
				mul_a   = $signed({1'b0, alpha_q});
				mul_b   = t_q;
				state_d = ST_NU;
			end
			ST_NU: state_d = ST_AV;
			ST_AV: begin
				mul_en  = 1'b1;
				mul_a   = $signed({1'b0, alpha_q});
				mul_b   = dv_q;
				state_d = ST_NV;
			end
			ST_NV: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Shared multiplier with registered product
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= mul_a * mul_b;
		end
	end

	// Intermediate terms of the Euler step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_VV: base_q <= (SUM_W'(v_q) <<< 2) + SUM_W'(v_q) + SUM_W'(K140)
				- SUM_W'(u_q) + SUM_W'(cur_q);
			ST_Q1: t_q    <= pq;
			ST_DV: dv_q   <= sat_sum(SUM_W'(pq) + base_q);
			ST_Q2: t_q    <= sat_sum(SUM_W'(pq) - SUM_W'(u_q));
			ST_Q3: t_q    <= pq;
			ST_NU: nu_q   <= sat_sum(SUM_W'(u_q) + SUM_W'(pq));
			default: ;
		endcase
	end

	// Neuron state, accumulator and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= RST_A;
			b_q     <= RST_B;
			c_q     <= RST_C;
			d_q     <= RST_D;
			alpha_q <= RST_ALPHA;
			v_q     <= RST_INIT_V;
			u_q     <= RST_INIT_U;
			cur_q   <= '0;
		end else begin
			// accumulate weights of spiking neighbors
			if (in_xfer && in_item.neighbor_spiked) begin
				cur_q <= sat_sum(SUM_W'(cur_q) + SUM_W'(in_item.synapse_weight));
			end
			// advance the neuron, apply spike reset, clear the accumulator
			if (commit) begin
				cur_q <= '0;
				if (fire) begin
					v_q <= c_q;
					u_q <= sat_sum(SUM_W'(nu_q) + SUM_W'(d_q));
				end else begin
					v_q <= nv;
					u_q <= nu_q;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_A:      a_q     <= cfg_data;
					REG_B:      b_q     <= cfg_data;
					REG_C:      c_q     <= cfg_data;
					REG_D:      d_q     <= cfg_data;
					REG_ALPHA:  alpha_q <= cfg_data[WORD_W-2:0];
					REG_INIT_V: v_q     <= cfg_data;
					REG_INIT_U: u_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Output register: load on commit, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.fired    <= fire;
			out_q.voltage  <= fire ? c_q : nv;
			out_q.recovery <= fire ? sat_sum(SUM_W'(nu_q) + SUM_W'(d_q)) : nu_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// A new result only appears from the final step
	a_rise_from_nv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_NV))
		else $error("result raised outside final step");

	// A non-firing result stays below threshold
	a_below_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.fired) |-> (out_q.voltage < K30))
		else $error("non-firing result at or above threshold");

	// Accumulator is frozen while the step is computed
	a_cur_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_NV) |=> $stable(cur_q))
		else $error("accumulator changed during step");

endmodule

[sim/izhikevich_neuron_step_tb.sv]
module izhikevich_neuron_step_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import izh_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 20;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 136;

	// Index past the last register; writes to it must be ignored
	localparam logic [2:0] REG_UNUSED = 3'd7;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint K_004 = ((longint'(4) <<< FRAC_BITS) + 50) / 100;
	localparam longint K_140 = longint'(140) <<< FRAC_BITS;
	localparam longint K_30  = longint'(30) <<< FRAC_BITS;
	localparam longint Q_ONE = longint'(1) <<< FRAC_BITS;

	typedef enum int {
		SET_BIOLOGICAL,
		SET_NOISE,
		SET_EXTREME
	} setting_kind_t;

	typedef struct {
		izh_in_t item;
		bit      drain;
	} neighbor_entry_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	izh_in_t           in_item   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	izh_out_t          out_item;
	logic              cfg_we    = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [WORD_W-1:0] cfg_data  = '0;

	// Neuron state and registers as the block should hold them
	longint rate_a, sens_b, volt_c, bump_d, step_alpha;
	longint neuron_v, neuron_u, syn_current;

	neighbor_entry_t neighbor_queue[$];
	izh_out_t        predicted_steps[$];

	int send_gap_pct   = 18;
	int recv_stall_pct = 73;
	int errors         = 0;
	int items_queued   = 0;
	int ticks_queued   = 0;
	int settings_count = 1;
	int results_seen   = 0;
	int fires_seen     = 0;
	int idle_cycles    = 0;

	izhikevich_neuron_step u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_word(input longint x);
		if (x > Q_MAX) begin
			return Q_MAX;
		end
		if (x < Q_MIN) begin
			return Q_MIN;
		end
		return x;
	endfunction

	// Exact product, floor to the fixed-point scale, clamp
	function automatic longint fx_mul(input longint x, input longint y);
		return clamp_word((x * y) >>> FRAC_BITS);
	endfunction

	task automatic model_reset();
		rate_a      = 1311;
		sens_b      = 13107;
		volt_c      = -4259840;
		bump_d      = 524288;
		step_alpha  = 65536;
		neuron_v    = -4259840;
		neuron_u    = -851968;
		syn_current = 0;
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [WORD_W-1:0] val);
		case (idx)
			REG_A: begin
				rate_a = longint'($signed(val));
			end
			REG_B: begin
				sens_b = longint'($signed(val));
			end
			REG_C: begin
				volt_c = longint'($signed(val));
			end
			REG_D: begin
				bump_d = longint'($signed(val));
			end
			REG_ALPHA: begin
				step_alpha = longint'(val[WORD_W-2:0]);
			end
			// initial values also load the live state
			REG_INIT_V: begin
				neuron_v = longint'($signed(val));
			end
			REG_INIT_U: begin
				neuron_u = longint'($signed(val));
			end
			default: begin
			end
		endcase
	endtask

	// Accumulate one neighbor; on the closing item take one Euler step
	task automatic advance_neuron(input izh_in_t it);
		longint dv, du, nv, nu;
		izh_out_t res;
		if (it.neighbor_spiked) begin
			syn_current = clamp_word(syn_current + longint'($signed(it.synapse_weight)));
		end
		if (it.last_of_tick) begin
			dv = clamp_word(fx_mul(K_004, fx_mul(neuron_v, neuron_v)) + 5 * neuron_v
				+ K_140 - neuron_u + syn_current);
			du = fx_mul(rate_a, clamp_word(fx_mul(sens_b, neuron_v) - neuron_u));
			nv = clamp_word(neuron_v + fx_mul(step_alpha, dv));
			nu = clamp_word(neuron_u + fx_mul(step_alpha, du));
			res.fired = (nv >= K_30);
			if (res.fired) begin
				nv = volt_c;
				nu = clamp_word(nu + bump_d);
			end
			neuron_v     = nv;
			neuron_u     = nu;
			syn_current  = 0;
			res.voltage  = nv[WORD_W-1:0];
			res.recovery = nu[WORD_W-1:0];
			predicted_steps = {predicted_steps, res};
		end
	endtask

	// Feed neighbor items, holding each one steady while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_neuron(in_item);
			end
			if (!in_valid || !in_stall) begin
				if (neighbor_queue.size() != 0
						&& !(neighbor_queue[0].drain && predicted_steps.size() != 0)
						&& $urandom_range(0, 99) >= send_gap_pct) begin
					in_item  <= neighbor_queue[0].item;
					in_valid <= 1'b1;
					void'(neighbor_queue.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each step result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		izh_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (out_item.fired === 1'b1) begin
					fires_seen++;
				end
				if (predicted_steps.size() == 0) begin
					$display("%0t: unexpected result fired=%0b voltage=%0d recovery=%0d",
						$time, out_item.fired, out_item.voltage, out_item.recovery);
					errors++;
				end else begin
					want = predicted_steps.pop_front();
					if (out_item.fired !== want.fired) begin
						$display("%0t: fired expected %0b actual %0b",
							$time, want.fired, out_item.fired);
						errors++;
					end
					if (out_item.voltage !== want.voltage) begin
						$display("%0t: voltage expected %0d actual %0d",
							$time, want.voltage, out_item.voltage);
						errors++;
					end
					if (out_item.recovery !== want.recovery) begin
						$display("%0t: recovery expected %0d actual %0d",
							$time, want.recovery, out_item.recovery);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("izhikevich_neuron_step test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [WORD_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return 32'd1;
			default: return '1;
		endcase
	endfunction

	// Mostly weights in a useful range, some raw noise, some extremes
	function automatic logic [WORD_W-1:0] rand_weight();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return $urandom_range(0, 2293760) - 32'd327680;
		end
		if (pick < 85) begin
			return $urandom;
		end
		return pick_extreme();
	endfunction

	// Append one neighbor item to the send queue
	task automatic add_neighbor(input izh_in_t it, input bit drain);
		neighbor_entry_t ent;
		ent.item       = it;
		ent.drain      = drain;
		neighbor_queue = {neighbor_queue, ent};
	endtask

	task automatic push_item(input bit spiked, input logic [WORD_W-1:0] weight, input bit last);
		izh_in_t it;
		it.neighbor_spiked = spiked;
		it.synapse_weight  = weight;
		it.last_of_tick    = last;
		add_neighbor(it, 1'b0);
		items_queued++;
		if (last) begin
			ticks_queued++;
		end
	endtask

	// One tick: a run of neighbors closed by the last one
	task automatic queue_tick(input bit drain);
		int len;
		izh_in_t it;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int k = 0; k < len; k++) begin
			it.neighbor_spiked = $urandom_range(0, 1);
			it.synapse_weight  = rand_weight();
			it.last_of_tick    = (k == len - 1);
			add_neighbor(it, drain && k == 0);
		end
		items_queued += len;
		ticks_queued++;
	endtask

	// Wait until every item is sent and every result is back
	task automatic wait_quiet();
		do @(negedge clk);
		while (neighbor_queue.size() != 0 || in_valid || predicted_steps.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
	endtask

	task automatic program_regs(input logic [WORD_W-1:0] a, b, c, d, alpha, iv, iu);
		logic [WORD_W-1:0] vals [7];
		vals = '{a, b, c, d, alpha, iv, iu};
		foreach (vals[i]) begin
			write_reg(3'(i), vals[i]);
		end
		write_reg(REG_UNUSED, $urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_count++;
	endtask

	task automatic program_random(input setting_kind_t kind);
		logic [WORD_W-1:0] v [7];
		case (kind)
			SET_BIOLOGICAL: begin
				v[REG_A] = $urandom_range(0, 6554);
				v[REG_B] = $urandom_range(0, 19661);
				v[REG_C] = -$urandom_range(3276800, 4587520);
				v[REG_D] = $urandom_range(0, 655360);
				case ($urandom_range(0, 3))
					0: v[REG_ALPHA] = Q_ONE[WORD_W-1:0];
					1: v[REG_ALPHA] = 32'd32768;
					2: v[REG_ALPHA] = 32'd16384;
					default: v[REG_ALPHA] = $urandom_range(0, 131072);
				endcase
				v[REG_INIT_V] = -$urandom_range(3932160, 4587520);
				v[REG_INIT_U] = -$urandom_range(0, 1310720);
			end
			SET_NOISE: begin
				foreach (v[i]) begin
					v[i] = $urandom;
				end
			end
			default: begin
				foreach (v[i]) begin
					v[i] = pick_extreme();
				end
				case ($urandom_range(0, 4))
					0: v[REG_ALPHA] = '0;
					1: v[REG_ALPHA] = 32'd1;
					2: v[REG_ALPHA] = Q_ONE[WORD_W-1:0];
					3: v[REG_ALPHA] = 32'h7FFF_FFFF;
					default: v[REG_ALPHA] = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		program_regs(v[REG_A], v[REG_B], v[REG_C], v[REG_D], v[REG_ALPHA],
			v[REG_INIT_V], v[REG_INIT_U]);
	endtask

	initial begin
		int phase_start;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at reset settings
		push_item(1'b0, WORD_MAX, 1'b1);
		push_item(1'b1, 32'd655360, 1'b1);
		push_item(1'b1, WORD_MAX, 1'b0);
		push_item(1'b1, WORD_MAX, 1'b0);
		push_item(1'b1, 32'd5, 1'b1);
		push_item(1'b1, WORD_MIN, 1'b0);
		push_item(1'b1, WORD_MIN, 1'b0);
		push_item(1'b0, '0, 1'b1);
		push_item(1'b1, '1, 1'b0);
		push_item(1'b1, '0, 1'b1);
		repeat (4) push_item(1'b1, 32'd1310720, 1'b1);
		push_item(1'b0, 32'h5555_5555, 1'b0);
		push_item(1'b1, 32'hAAAA_AAAA, 1'b1);

		// Register extremes, including an alpha write with bit 31 set
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		program_regs(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, WORD_MAX, WORD_MIN);
		push_item(1'b1, WORD_MAX, 1'b1);
		push_item(1'b0, '0, 1'b1);
		push_item(1'b1, WORD_MIN, 1'b1);

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		program_regs(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, '0, WORD_MIN, WORD_MAX);
		push_item(1'b1, WORD_MIN, 1'b1);
		push_item(1'b0, '0, 1'b1);
		push_item(1'b1, WORD_MAX, 1'b1);

		// Random phases, each under a fresh register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_quiet();
			case (p / 4)
				0: begin
					send_gap_pct   = 18;
					recv_stall_pct = 73;
				end
				1: begin
					send_gap_pct   = 73;
					recv_stall_pct = 18;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (SETTLE_CYCLES) @(posedge clk);
			program_random(setting_kind_t'(p % 3));
			phase_start = items_queued;
			queue_tick(p == 0);
			while (items_queued - phase_start < PHASE_ITEMS) begin
				queue_tick($urandom_range(0, 19) == 0);
			end
		end

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predicted_steps.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, predicted_steps.size());
			errors++;
		end
		$display("Covered %0d neighbor items in %0d ticks across %0d register settings,",
			items_queued, ticks_queued, settings_count);
		$display("checking %0d step results, %0d of them spikes.", results_seen, fires_seen);
		if (errors == 0) begin
			$display("izhikevich_neuron_step test passed");
		end else begin
			$display("izhikevich_neuron_step test failed");
		end
		$finish;
	end

endmodule
